### rtl/core/char_lcd_nibble_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is asserted
`define LCDNS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define LCDNS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define LCDNS_ASSERT(label, prop, msg)
`define LCDNS_ASSERT_RST(label, prop, msg)

`endif

`endif

### rtl/core/lcdns_pkg.sv
package lcdns_pkg;

    // Request codes
    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_DATA    = 2'd2,
        ACT_CURSOR  = 2'd3
    } t_action;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMMAND_WAIT = 3'd0,
        CFG_DATA_WAIT    = 3'd1,
        CFG_FUNCTION_SET = 3'd2,
        CFG_ENTRY_MODE   = 3'd3,
        CFG_DISPLAY_CTRL = 3'd4,
        CFG_CURSOR_SHIFT = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] RST_COMMAND_WAIT = 16'd100;
    localparam logic [15:0] RST_DATA_WAIT    = 16'd120;
    localparam logic [7:0]  RST_FUNCTION_SET = 8'h2C;
    localparam logic [7:0]  RST_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  RST_DISPLAY_CTRL = 8'h0F;
    localparam logic [7:0]  RST_CURSOR_SHIFT = 8'h14;

    // Fixed bytes and holds
    localparam logic [7:0]  CLEAR_CMD       = 8'h01;
    localparam logic [7:0]  WAKE_NIBBLE     = 8'h03;
    localparam logic [7:0]  FOUR_BIT_NIBBLE = 8'h02;
    localparam logic [15:0] IDLE_US         = 16'd10000;
    localparam logic [15:0] WAKE_FIRST_US   = 16'd5000;
    localparam logic [15:0] WAKE_NEXT_US    = 16'd110;

    // Byte source for a microcode step
    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_WAKE,
        SRC_FOUR,
        SRC_CLEAR,
        SRC_FSET,
        SRC_ENTRY,
        SRC_DISP,
        SRC_SHIFT,
        SRC_REQ
    } t_src;

    // Hold source for a microcode step
    typedef enum logic [2:0] {
        HOLD_ZERO,
        HOLD_IDLE,
        HOLD_WAKE_FIRST,
        HOLD_WAKE_NEXT,
        HOLD_BYTE_WAIT
    } t_hold;

    // Microcode address and program entry points
    typedef logic [5:0] t_upc;
    localparam t_upc UPC_INIT = 6'd0;
    localparam t_upc UPC_REQ  = 6'd29;
    localparam t_upc UPC_LAST = 6'd33;

    // Control word: fin ends the run, fin_req ends it unless cursor positioning
    typedef struct packed {
        t_src  src;
        logic  nib_lo;
        logic  en;
        t_hold hold;
        logic  fin;
        logic  fin_req;
    } t_uword;

    // Step handed from the sequencer to the datapath
    typedef struct packed {
        logic  valid;
        t_src  src;
        logic  nib_lo;
        logic  en;
        t_hold hold;
        logic  last;
    } t_step;

    function automatic t_uword uop(input t_src s, input logic lo, input logic en,
                                   input t_hold h, input logic f, input logic fr);
        t_uword w;
        w.src     = s;
        w.nib_lo  = lo;
        w.en      = en;
        w.hold    = h;
        w.fin     = f;
        w.fin_req = fr;
        return w;
    endfunction

    // Microcode program
    function automatic t_uword ucode_rom(input t_upc addr);
        t_uword w;
        case (addr)
            // idle, then the wake-up nibbles
            6'd0:  w = uop(SRC_ZERO,  1'b1, 1'b0, HOLD_IDLE,       1'b0, 1'b0);
            6'd1:  w = uop(SRC_WAKE,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd2:  w = uop(SRC_WAKE,  1'b1, 1'b0, HOLD_WAKE_FIRST, 1'b0, 1'b0);
            6'd3:  w = uop(SRC_WAKE,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd4:  w = uop(SRC_WAKE,  1'b1, 1'b0, HOLD_WAKE_NEXT,  1'b0, 1'b0);
            6'd5:  w = uop(SRC_WAKE,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd6:  w = uop(SRC_WAKE,  1'b1, 1'b0, HOLD_WAKE_NEXT,  1'b0, 1'b0);
            6'd7:  w = uop(SRC_FOUR,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd8:  w = uop(SRC_FOUR,  1'b1, 1'b0, HOLD_WAKE_NEXT,  1'b0, 1'b0);
            // clear
            6'd9:  w = uop(SRC_CLEAR, 1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd10: w = uop(SRC_CLEAR, 1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd11: w = uop(SRC_CLEAR, 1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd12: w = uop(SRC_CLEAR, 1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b0, 1'b0);
            // function set
            6'd13: w = uop(SRC_FSET,  1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd14: w = uop(SRC_FSET,  1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd15: w = uop(SRC_FSET,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd16: w = uop(SRC_FSET,  1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b0, 1'b0);
            // entry mode
            6'd17: w = uop(SRC_ENTRY, 1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd18: w = uop(SRC_ENTRY, 1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd19: w = uop(SRC_ENTRY, 1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd20: w = uop(SRC_ENTRY, 1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b0, 1'b0);
            // display control
            6'd21: w = uop(SRC_DISP,  1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd22: w = uop(SRC_DISP,  1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd23: w = uop(SRC_DISP,  1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd24: w = uop(SRC_DISP,  1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b0, 1'b0);
            // cursor shift, end of init
            6'd25: w = uop(SRC_SHIFT, 1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd26: w = uop(SRC_SHIFT, 1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd27: w = uop(SRC_SHIFT, 1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd28: w = uop(SRC_SHIFT, 1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b1, 1'b0);
            // request byte; cursor positioning falls through to an extra wait
            6'd29: w = uop(SRC_REQ,   1'b0, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd30: w = uop(SRC_REQ,   1'b0, 1'b0, HOLD_ZERO,       1'b0, 1'b0);
            6'd31: w = uop(SRC_REQ,   1'b1, 1'b1, HOLD_ZERO,       1'b0, 1'b0);
            6'd32: w = uop(SRC_REQ,   1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b0, 1'b1);
            6'd33: w = uop(SRC_REQ,   1'b1, 1'b0, HOLD_BYTE_WAIT,  1'b1, 1'b0);
            default: w = uop(SRC_ZERO, 1'b1, 1'b0, HOLD_ZERO,      1'b1, 1'b0);
        endcase
        return w;
    endfunction

endpackage

### rtl/core/lcdns_seq.sv
`include "char_lcd_nibble_sequencer_defines.svh"

module lcdns_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_action,
    output logic                  busy,
    output lcdns_pkg::t_step      o_step
);

    logic               r_busy,   n_busy;
    lcdns_pkg::t_upc    r_upc,    n_upc;
    logic               r_cursor, n_cursor;
    lcdns_pkg::t_uword  uword;
    logic               accept;
    logic               step_last;

    assign accept = start && !r_busy;

    // Fetch the control word of the current step
    assign uword     = lcdns_pkg::ucode_rom(r_upc);
    assign step_last = uword.fin || (uword.fin_req && !r_cursor);

    // Hand the step to the datapath
    always_comb begin
        o_step.valid  = r_busy;
        o_step.src    = uword.src;
        o_step.nib_lo = uword.nib_lo;
        o_step.en     = uword.en;
        o_step.hold   = uword.hold;
        o_step.last   = step_last;
    end

    // Advance the step counter, stop on the last step, load entry on transfer
    always_comb begin
        n_busy   = r_busy;
        n_upc    = r_upc;
        n_cursor = r_cursor;
        if (accept) begin
            n_busy   = 1'b1;
            n_cursor = (lcdns_pkg::t_action'(i_action) == lcdns_pkg::ACT_CURSOR);
            n_upc    = (lcdns_pkg::t_action'(i_action) == lcdns_pkg::ACT_INIT)
                       ? lcdns_pkg::UPC_INIT : lcdns_pkg::UPC_REQ;
        end else if (r_busy) begin
            if (step_last) begin
                n_busy = 1'b0;
            end else begin
                n_upc = r_upc + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_upc    <= lcdns_pkg::UPC_INIT;
            r_cursor <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_upc    <= n_upc;
            r_cursor <= n_cursor;
        end
    end

    assign busy = r_busy;

    `LCDNS_ASSERT_RST(a_rst_idle, !i_rst_n |=> !r_busy, "sequencer busy after reset")
    `LCDNS_ASSERT(a_pc_range, r_busy |-> (r_upc <= lcdns_pkg::UPC_LAST), "step counter out of range")
    `LCDNS_ASSERT(a_start_runs, accept |=> r_busy, "transfer did not start a run")
    `LCDNS_ASSERT(a_last_stops, (r_busy && step_last) |=> !r_busy, "run did not stop on last step")

endmodule

### rtl/core/lcdns_datapath.sv
`include "char_lcd_nibble_sequencer_defines.svh"

module lcdns_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [1:0]                       i_action,
    input  logic [7:0]                       i_payload_byte,
    input  logic                             i_row_select,
    input  logic [5:0]                       i_column,
    input  logic                             i_cfg_we,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcdns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  lcdns_pkg::t_step                 i_step,
    output logic                             o_strobe,
    output logic                             o_pin_rs,
    output logic                             o_pin_enable,
    output logic [3:0]                       o_pin_data,
    output logic [15:0]                      o_hold_us,
    output logic                             o_last
);

    logic [15:0] r_command_wait;
    logic [15:0] r_data_wait;
    logic [7:0]  r_function_set;
    logic [7:0]  r_entry_mode;
    logic [7:0]  r_display_ctrl;
    logic [7:0]  r_cursor_shift;

    logic [7:0]  r_req_byte;
    logic        r_req_rs;

    logic        r_strobe;
    logic        r_pin_rs;
    logic        r_pin_enable;
    logic [3:0]  r_pin_data;
    logic [15:0] r_hold_us;
    logic        r_last;

    logic [7:0]  src_byte;
    logic [15:0] hold_val;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_wait <= lcdns_pkg::RST_COMMAND_WAIT;
            r_data_wait    <= lcdns_pkg::RST_DATA_WAIT;
            r_function_set <= lcdns_pkg::RST_FUNCTION_SET;
            r_entry_mode   <= lcdns_pkg::RST_ENTRY_MODE;
            r_display_ctrl <= lcdns_pkg::RST_DISPLAY_CTRL;
            r_cursor_shift <= lcdns_pkg::RST_CURSOR_SHIFT;
        end else if (i_cfg_we) begin
            case (lcdns_pkg::t_cfg_idx'(i_cfg_index))
                lcdns_pkg::CFG_COMMAND_WAIT: r_command_wait <= i_cfg_data;
                lcdns_pkg::CFG_DATA_WAIT:    r_data_wait    <= i_cfg_data;
                lcdns_pkg::CFG_FUNCTION_SET: r_function_set <= i_cfg_data[7:0];
                lcdns_pkg::CFG_ENTRY_MODE:   r_entry_mode   <= i_cfg_data[7:0];
                lcdns_pkg::CFG_DISPLAY_CTRL: r_display_ctrl <= i_cfg_data[7:0];
                lcdns_pkg::CFG_CURSOR_SHIFT: r_cursor_shift <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Capture the request byte and register select on transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (lcdns_pkg::t_action'(i_action) == lcdns_pkg::ACT_CURSOR) begin
                r_req_byte <= {1'b1, i_row_select, i_column};
            end else begin
                r_req_byte <= i_payload_byte;
            end
            r_req_rs <= (lcdns_pkg::t_action'(i_action) == lcdns_pkg::ACT_DATA);
        end
    end

    // Select the byte for this step
    always_comb begin
        case (i_step.src)
            lcdns_pkg::SRC_ZERO:  src_byte = 8'h00;
            lcdns_pkg::SRC_WAKE:  src_byte = lcdns_pkg::WAKE_NIBBLE;
            lcdns_pkg::SRC_FOUR:  src_byte = lcdns_pkg::FOUR_BIT_NIBBLE;
            lcdns_pkg::SRC_CLEAR: src_byte = lcdns_pkg::CLEAR_CMD;
            lcdns_pkg::SRC_FSET:  src_byte = r_function_set;
            lcdns_pkg::SRC_ENTRY: src_byte = r_entry_mode;
            lcdns_pkg::SRC_DISP:  src_byte = r_display_ctrl;
            lcdns_pkg::SRC_SHIFT: src_byte = r_cursor_shift;
            lcdns_pkg::SRC_REQ:   src_byte = r_req_byte;
            default:              src_byte = 8'h00;
        endcase
    end

    // Select the hold for this step; the byte wait follows register select
    always_comb begin
        case (i_step.hold)
            lcdns_pkg::HOLD_ZERO:       hold_val = 16'd0;
            lcdns_pkg::HOLD_IDLE:       hold_val = lcdns_pkg::IDLE_US;
            lcdns_pkg::HOLD_WAKE_FIRST: hold_val = lcdns_pkg::WAKE_FIRST_US;
            lcdns_pkg::HOLD_WAKE_NEXT:  hold_val = lcdns_pkg::WAKE_NEXT_US;
            lcdns_pkg::HOLD_BYTE_WAIT:  hold_val = r_req_rs ? r_data_wait : r_command_wait;
            default:                    hold_val = 16'd0;
        endcase
    end

    // Register the pin state; only the strobe needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_step.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.valid) begin
            r_pin_rs     <= r_req_rs;
            r_pin_enable <= i_step.en;
            r_pin_data   <= i_step.nib_lo ? src_byte[3:0] : src_byte[7:4];
            r_hold_us    <= hold_val;
            r_last       <= i_step.last;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pin_rs     = r_pin_rs;
    assign o_pin_enable = r_pin_enable;
    assign o_pin_data   = r_pin_data;
    assign o_hold_us    = r_hold_us;
    assign o_last       = r_last;

    `LCDNS_ASSERT(a_gap_after_last, (r_strobe && r_last) |=> !r_strobe, "pin state right after last")
    `LCDNS_ASSERT(a_load_idle, i_load |-> !i_step.valid, "request loaded during a run")
    `LCDNS_ASSERT(a_enable_no_hold, (r_strobe && r_pin_enable) |-> (r_hold_us == 16'd0), "enable high with a hold")

endmodule

### rtl/core/char_lcd_nibble_sequencer.sv
// Character LCD 4-bit sequencer. Raise start with an action while busy is low;
// the request is taken at that edge and busy rises. Pin states then appear one
// per clock, each valid for exactly one cycle while o_strobe is high, after the
// request has passed the sequencer state register and the pin output register;
// o_last marks the final one, and busy is already low in that cycle, so a new
// request can be taken at the edge that ends it. The receiver cannot stall and
// must capture every strobed state (typically into a FIFO in front of the pin
// timer). A run is 29 states for init, 4 for a command or data byte and 5 for
// cursor positioning; the rate is set by the microcode step counter, which
// issues one control word per clock. Configuration writes take effect at once
// and belong in idle time only.
module char_lcd_nibble_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_action,
    input  logic [7:0]                       i_payload_byte,
    input  logic                             i_row_select,
    input  logic [5:0]                       i_column,
    input  logic                             i_cfg_we,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcdns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_strobe,
    output logic                             o_pin_rs,
    output logic                             o_pin_enable,
    output logic [3:0]                       o_pin_data,
    output logic [15:0]                      o_hold_us,
    output logic                             o_last
);

    lcdns_pkg::t_step step;
    logic             load;

    assign load = start && !busy;

    // Step counter and microcode
    lcdns_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_step   (step)
    );

    // Operand select, configuration and pin output registers
    lcdns_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_action       (i_action),
        .i_payload_byte (i_payload_byte),
        .i_row_select   (i_row_select),
        .i_column       (i_column),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_step         (step),
        .o_strobe       (o_strobe),
        .o_pin_rs       (o_pin_rs),
        .o_pin_enable   (o_pin_enable),
        .o_pin_data     (o_pin_data),
        .o_hold_us      (o_hold_us),
        .o_last         (o_last)
    );

endmodule

### test/char_lcd_pin_checker.sv
`timescale 1ns / 1ps

// Watches the request, register and pin-state channels, predicts every pin
// state from the accepted requests and compares them in order.
module char_lcd_pin_checker
    import lcdns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_payload_byte,
    input  logic                  i_row_select,
    input  logic [5:0]            i_column,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_strobe,
    input  logic                  i_pin_rs,
    input  logic                  i_pin_enable,
    input  logic [3:0]            i_pin_data,
    input  logic [15:0]           i_hold_us,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BIT  = 8'h40;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  data;
        logic [15:0] hold;
        logic        last;
    } t_pin_state;

    // Shadow copy of the register file
    logic [15:0] command_wait;
    logic [15:0] data_wait;
    logic [7:0]  function_set;
    logic [7:0]  entry_mode;
    logic [7:0]  display_ctrl;
    logic [7:0]  cursor_shift;

    t_pin_state expected_pins[$];
    int         mismatches = 0;
    int         pending_pins = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_pins;

    task automatic put_state(input logic rs, input logic en, input logic [3:0] nib,
                             input logic [15:0] hold);
        t_pin_state s;
        s.rs   = rs;
        s.en   = en;
        s.data = nib;
        s.hold = hold;
        s.last = 1'b0;
        expected_pins.push_back(s);
    endtask

    // Enable high with the nibble, then enable low holding it
    task automatic put_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] hold);
        put_state(rs, 1'b1, nib, 16'd0);
        put_state(rs, 1'b0, nib, hold);
    endtask

    task automatic put_byte(input logic rs, input logic [7:0] b, input logic [15:0] hold);
        put_nibble(rs, b[7:4], 16'd0);
        put_nibble(rs, b[3:0], hold);
    endtask

    // Expand one request into its pin states and mark the final one
    task automatic plan_request(input t_action act, input logic [7:0] payload,
                                input logic row, input logic [5:0] col);
        logic [7:0] cursor_cmd;
        t_pin_state tail;
        cursor_cmd = LINE1_BASE | (row ? LINE2_BIT : 8'h00) | {2'b00, col};
        case (act)
            ACT_INIT: begin
                put_state(1'b0, 1'b0, 4'h0, IDLE_US);
                put_nibble(1'b0, WAKE_NIBBLE[3:0], WAKE_FIRST_US);
                put_nibble(1'b0, WAKE_NIBBLE[3:0], WAKE_NEXT_US);
                put_nibble(1'b0, WAKE_NIBBLE[3:0], WAKE_NEXT_US);
                put_nibble(1'b0, FOUR_BIT_NIBBLE[3:0], WAKE_NEXT_US);
                put_byte(1'b0, CLEAR_CMD, command_wait);
                put_byte(1'b0, function_set, command_wait);
                put_byte(1'b0, entry_mode, command_wait);
                put_byte(1'b0, display_ctrl, command_wait);
                put_byte(1'b0, cursor_shift, command_wait);
            end
            ACT_COMMAND: put_byte(1'b0, payload, command_wait);
            ACT_DATA:    put_byte(1'b1, payload, data_wait);
            default: begin
                // cursor move: the byte, then one more state holding the wait
                put_byte(1'b0, cursor_cmd, command_wait);
                put_state(1'b0, 1'b0, cursor_cmd[3:0], command_wait);
            end
        endcase
        tail = expected_pins.pop_back();
        tail.last = 1'b1;
        expected_pins.push_back(tail);
    endtask

    task automatic check_field(input string name, input int unsigned exp,
                               input int unsigned got);
        if (exp != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pin_state want;
        if (!i_rst_n) begin
            command_wait = RST_COMMAND_WAIT;
            data_wait    = RST_DATA_WAIT;
            function_set = RST_FUNCTION_SET;
            entry_mode   = RST_ENTRY_MODE;
            display_ctrl = RST_DISPLAY_CTRL;
            cursor_shift = RST_CURSOR_SHIFT;
            expected_pins.delete();
        end else begin
            // Track register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COMMAND_WAIT: command_wait = i_cfg_data;
                    CFG_DATA_WAIT:    data_wait    = i_cfg_data;
                    CFG_FUNCTION_SET: function_set = i_cfg_data[7:0];
                    CFG_ENTRY_MODE:   entry_mode   = i_cfg_data[7:0];
                    CFG_DISPLAY_CTRL: display_ctrl = i_cfg_data[7:0];
                    CFG_CURSOR_SHIFT: cursor_shift = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // Compare each strobed pin state against the oldest prediction
            if (i_strobe) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t: unexpected pin state: expected none, actual rs=%0b en=%0b data=%h hold=%0d last=%0b",
                             $time, i_pin_rs, i_pin_enable, i_pin_data, i_hold_us, i_last);
                    mismatches++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("pin_rs", want.rs, i_pin_rs);
                    check_field("pin_enable", want.en, i_pin_enable);
                    check_field("pin_data", want.data, i_pin_data);
                    check_field("hold_us", want.hold, i_hold_us);
                    check_field("last", want.last, i_last);
                end
            end

            // Predict on every request transfer
            if (i_start && !i_busy)
                plan_request(t_action'(i_action), i_payload_byte, i_row_select, i_column);
        end
        pending_pins = expected_pins.size();
    end

endmodule

### test/tb_char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;
    import lcdns_pkg::*;

    localparam int STALL_LIMIT = 500;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = CFG_IDX_W'(CFG_CURSOR_SHIFT + 1);
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_action = ACT_INIT;
    logic [7:0]            i_payload_byte = '0;
    logic                  i_row_select = 1'b0;
    logic [5:0]            i_column = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_COMMAND_WAIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic                  o_pin_rs;
    logic                  o_pin_enable;
    logic [3:0]            o_pin_data;
    logic [15:0]           o_hold_us;
    logic                  o_last;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit idling_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    char_lcd_nibble_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_payload_byte (i_payload_byte),
        .i_row_select   (i_row_select),
        .i_column       (i_column),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_pin_rs       (o_pin_rs),
        .o_pin_enable   (o_pin_enable),
        .o_pin_data     (o_pin_data),
        .o_hold_us      (o_hold_us),
        .o_last         (o_last)
    );

    char_lcd_pin_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_payload_byte (i_payload_byte),
        .i_row_select   (i_row_select),
        .i_column       (i_column),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_strobe       (o_strobe),
        .i_pin_rs       (o_pin_rs),
        .i_pin_enable   (o_pin_enable),
        .i_pin_data     (o_pin_data),
        .i_hold_us      (o_hold_us),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Abort when neither a request nor a pin state moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("char_lcd_nibble_sequencer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one request, with an optional idle burst first, and hold it until transfer
    task automatic send_request(input t_action act, input logic [7:0] payload,
                                input logic row, input logic [5:0] col);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_payload_byte <= payload;
        i_row_select   <= row;
        i_column       <= col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and wait until every predicted pin state is out and the block is idle
    task automatic quiet_down();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all six registers, one per cycle, then drop the write enable
    task automatic load_settings(input logic [15:0] cmd_wait, input logic [15:0] dat_wait,
                                 input logic [15:0] fset, input logic [15:0] entry,
                                 input logic [15:0] disp, input logic [15:0] shift);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [15:0]          val [6];
        idx = '{CFG_COMMAND_WAIT, CFG_DATA_WAIT, CFG_FUNCTION_SET,
                CFG_ENTRY_MODE, CFG_DISPLAY_CTRL, CFG_CURSOR_SHIFT};
        val = '{cmd_wait, dat_wait, fset, entry, disp, shift};
        for (int i = 0; i < 6; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random requests; init is kept rare since it is long
    task automatic random_requests(input int count, input int drain_at);
        t_action    act;
        logic [5:0] col;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       act = ACT_INIT;
                1, 2, 3: act = ACT_COMMAND;
                4, 5, 6: act = ACT_DATA;
                default: act = ACT_CURSOR;
            endcase
            col = 6'($urandom);
            if ($urandom_range(0, 3) == 0)
                col = $urandom_range(0, 1) ? 6'h3F : 6'h00;
            if (n == drain_at)
                quiet_down();
            send_request(act, 8'($urandom), 1'($urandom), col);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every action, field extremes, ignored fields at extremes
        send_request(ACT_INIT, 8'hFF, 1'b1, 6'h3F);
        send_request(ACT_COMMAND, 8'h00, 1'b1, 6'h3F);
        send_request(ACT_COMMAND, 8'hFF, 1'b0, 6'h00);
        send_request(ACT_DATA, 8'h00, 1'b0, 6'h00);
        send_request(ACT_DATA, 8'hFF, 1'b1, 6'h3F);
        send_request(ACT_CURSOR, 8'hFF, 1'b0, 6'h00);
        send_request(ACT_CURSOR, 8'h00, 1'b1, 6'h3F);
        send_request(ACT_CURSOR, 8'hA5, 1'b0, 6'h3F);
        send_request(ACT_CURSOR, 8'h5A, 1'b1, 6'h00);
        quiet_down();

        // Short command wait, long data wait; upper bits must be masked off the bytes,
        // and writes to indexes past the list must change nothing
        load_settings(16'h0000, 16'hFFFF, 16'hFF00, 16'hFFFF, 16'hAA55, 16'h55AA);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= SPARE_IDX_LO;
        i_cfg_data  <= 16'hFFFF;
        @(negedge i_clk);
        i_cfg_index <= SPARE_IDX_HI;
        i_cfg_data  <= 16'h0000;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_request(ACT_INIT, 8'h00, 1'b0, 6'h00);
        send_request(ACT_COMMAND, 8'hA5, 1'b0, 6'h00);
        send_request(ACT_DATA, 8'h5A, 1'b0, 6'h00);
        send_request(ACT_CURSOR, 8'h00, 1'b1, 6'h2A);
        quiet_down();

        // Long command wait, zero data wait
        load_settings(16'hFFFF, 16'h0000, 16'h00FF, 16'h0000, 16'hFFFF, 16'hFF00);
        send_request(ACT_INIT, 8'h00, 1'b0, 6'h00);
        send_request(ACT_COMMAND, 8'h3C, 1'b0, 6'h00);
        send_request(ACT_DATA, 8'hC3, 1'b0, 6'h00);
        send_request(ACT_CURSOR, 8'h00, 1'b0, 6'h15);
        quiet_down();

        // Random settings and requests; the last pass runs without idle bursts
        load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        random_requests(31, -1);
        quiet_down();
        load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        random_requests(31, 15);
        quiet_down();
        load_settings(RST_COMMAND_WAIT, RST_DATA_WAIT, {8'h00, RST_FUNCTION_SET},
                      {8'h00, RST_ENTRY_MODE}, {8'h00, RST_DISPLAY_CTRL},
                      {8'h00, RST_CURSOR_SHIFT});
        idling_on = 1'b0;
        random_requests(31, -1);

        // Let the last runs drain and catch any stray pin state
        quiet_down();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0)
            $display("char_lcd_nibble_sequencer test passed");
        else
            $display("char_lcd_nibble_sequencer test failed");
        $finish;
    end

endmodule
